FILE: hdl/wbfs_pkg.sv
// wbfs_pkg: shared widths, command codes, sequencer states and defaults
// for the weight bounded fifo shelf; used by the interfaces and the top level
// no dependencies
package wbfs_pkg;

    localparam int SLOTS_DEF    = 64;
    localparam int ID_COUNT_DEF = 128;

    localparam int CMD_W   = 2;
    localparam int ID_W    = 7;
    localparam int WIDTH_W = 16;
    localparam int PROB_W  = 16;
    localparam int SUM_W   = 17;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_END    = 2'd2;

    localparam logic [PROB_W-1:0] PROB_MAX = 16'hFFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_EV_CHECK,
        ST_EV_ID,
        ST_EV_W,
        ST_RM_WID,
        ST_RM_RD,
        ST_RM_DATA,
        ST_DUMP_RD,
        ST_DUMP_OUT
    } state_t;

endpackage

FILE: hdl/wbfs_req_if.sv
// wbfs_req_if: command channel of the shelf, valid/ready plus payload
// depends on wbfs_pkg
interface wbfs_req_if;
    logic                         valid;
    logic                         ready;
    logic [wbfs_pkg::CMD_W-1:0]   cmd;
    logic [wbfs_pkg::ID_W-1:0]    item_id;
    logic [wbfs_pkg::WIDTH_W-1:0] item_width;

    modport source (output valid, output cmd, output item_id, output item_width,
                    input ready);
    modport sink (input valid, input cmd, input item_id, input item_width,
                  output ready);
endinterface

FILE: hdl/wbfs_rsp_if.sv
// wbfs_rsp_if: result channel of the shelf, valid/ready plus payload
// depends on wbfs_pkg
interface wbfs_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [wbfs_pkg::ID_W-1:0]   out_id;
    logic [wbfs_pkg::PROB_W-1:0] problem_number;
    logic                        list_empty;
    logic                        overflow;
    logic                        last;

    modport source (output valid, output out_id, output problem_number,
                    output list_empty, output overflow, output last, input ready);
    modport sink (input valid, input out_id, input problem_number,
                  input list_empty, input overflow, input last, output ready);
endinterface

FILE: hdl/wbfs_ram.sv
// wbfs_ram: generic single write port, single read port ram, registered read
// no dependencies
module wbfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/weight_bounded_fifo_shelf.sv
// weight_bounded_fifo_shelf: top level, capacity bounded list of item ids
// depends on wbfs_pkg, wbfs_req_if, wbfs_rsp_if, wbfs_ram
//
//   channel | dir | handshake    | word
//   req     | in  | valid/ready  | cmd, item_id, item_width
//   rsp     | out | valid/ready  | out_id, problem_number, list_empty, overflow, last
//   cfg     | in  | cfg_we       | cfg_wdata = shelf_capacity
//
// one sequencer steps through the order ram and the width ram, one access each a cycle
// add: ADD, EV_CHECK, EV_ID/EV_W per eviction; remove: RM_WID, RM_RD, RM_DATA/RM_RD per item
// end: DUMP_RD, DUMP_OUT per word, DUMP_OUT alone for an empty list, held while rsp stalls
// req.ready is high only while idle; the rsp register can reload while its word is taken
// reset clears control state only; no ram clearing pass, entries are written before read
module weight_bounded_fifo_shelf #(
    parameter int SLOTS    = wbfs_pkg::SLOTS_DEF,
    parameter int ID_COUNT = wbfs_pkg::ID_COUNT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [wbfs_pkg::WIDTH_W-1:0] cfg_wdata,
    wbfs_req_if.sink                     req,
    wbfs_rsp_if.source                   rsp
);

    localparam int PW    = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int SW    = PW + 1;
    localparam int ID_AW = $clog2(ID_COUNT);
    localparam int XW    = ID_AW + wbfs_pkg::ID_W;

    localparam int ID_W    = wbfs_pkg::ID_W;
    localparam int WIDTH_W = wbfs_pkg::WIDTH_W;
    localparam int SUM_W   = wbfs_pkg::SUM_W;
    localparam int PROB_W  = wbfs_pkg::PROB_W;

    wbfs_pkg::state_t state_reg, state_next;

    logic [WIDTH_W-1:0] cap_reg, cap_next;
    logic [PW-1:0]      head_reg, head_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic               ovf_reg, ovf_next;
    logic [PROB_W-1:0]  prob_reg, prob_next;
    logic [CW-1:0]      r_reg, r_next;
    logic [CW-1:0]      k_reg, k_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [WIDTH_W-1:0] wadd_reg, wadd_next;
    logic [WIDTH_W-1:0] wsub_reg, wsub_next;

    logic               out_valid_reg, out_valid_next;
    logic [ID_W-1:0]    out_id_reg, out_id_next;
    logic [PROB_W-1:0]  out_prob_reg, out_prob_next;
    logic               out_empty_reg, out_empty_next;
    logic               out_ovf_reg, out_ovf_next;
    logic               out_last_reg, out_last_next;

    logic               o_we, o_re;
    logic [PW-1:0]      o_waddr, o_raddr;
    logic [ID_W-1:0]    o_wdata, o_rdata;
    logic               w_we, w_re;
    logic [ID_AW-1:0]   w_waddr, w_raddr;
    logic [WIDTH_W-1:0] w_wdata, w_rdata;

    logic               accept;
    logic               out_free;
    logic               id_ok;
    logic               evict;
    logic               dump_last;
    logic [CW-1:0]      r_inc;
    logic [CW-1:0]      ph_off;
    logic [SW-1:0]      ph_sum;
    logic [PW-1:0]      phys;
    logic [PW-1:0]      head_dec;

    function automatic logic [ID_AW-1:0] wt_addr(input logic [ID_W-1:0] id);
        logic [XW-1:0] ext;
        ext = XW'(id);
        return ext[ID_AW-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] sat_sub(input logic [SUM_W-1:0] s,
                                                 input logic [WIDTH_W-1:0] w);
        logic [SUM_W-1:0] wx;
        wx = SUM_W'(w);
        return (s > wx) ? (s - wx) : '0;
    endfunction

    wbfs_ram #(
        .WIDTH (ID_W),
        .DEPTH (SLOTS)
    ) u_order_ram (
        .clk   (clk),
        .we    (o_we),
        .waddr (o_waddr),
        .wdata (o_wdata),
        .re    (o_re),
        .raddr (o_raddr),
        .rdata (o_rdata)
    );

    wbfs_ram #(
        .WIDTH (WIDTH_W),
        .DEPTH (ID_COUNT)
    ) u_width_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .re    (w_re),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    assign accept    = req.valid && (state_reg == wbfs_pkg::ST_IDLE);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign id_ok     = (32'(req.item_id) < ID_COUNT);
    assign evict     = (sum_reg > SUM_W'(cap_reg)) && (count_reg != '0);
    assign r_inc     = r_reg + 1'b1;
    assign dump_last = (count_reg == '0) || (r_inc == count_reg);
    assign head_dec  = (head_reg == '0) ? PW'(SLOTS - 1) : (head_reg - 1'b1);

    // logical list position to ram address, front at head
    always_comb
    begin
        case (state_reg)
            wbfs_pkg::ST_EV_CHECK: ph_off = count_reg - 1'b1;
            wbfs_pkg::ST_RM_DATA:  ph_off = k_reg;
            default:               ph_off = r_reg;
        endcase
        ph_sum = SW'(head_reg) + SW'(ph_off);
        if (ph_sum >= SW'(SLOTS))
        begin
            ph_sum = ph_sum - SW'(SLOTS);
        end
        phys = ph_sum[PW-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wbfs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.cmd)
                        wbfs_pkg::CMD_ADD:
                        begin
                            if (id_ok && (count_reg < CW'(SLOTS)))
                            begin
                                state_next = wbfs_pkg::ST_ADD;
                            end
                        end
                        wbfs_pkg::CMD_REMOVE:
                        begin
                            if (id_ok)
                            begin
                                state_next = wbfs_pkg::ST_RM_WID;
                            end
                        end
                        wbfs_pkg::CMD_END:
                        begin
                            state_next = (count_reg == '0) ? wbfs_pkg::ST_DUMP_OUT
                                                           : wbfs_pkg::ST_DUMP_RD;
                        end
                        default:
                        begin
                            state_next = wbfs_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            wbfs_pkg::ST_ADD:      state_next = wbfs_pkg::ST_EV_CHECK;
            wbfs_pkg::ST_EV_CHECK: state_next = evict ? wbfs_pkg::ST_EV_ID : wbfs_pkg::ST_IDLE;
            wbfs_pkg::ST_EV_ID:    state_next = wbfs_pkg::ST_EV_W;
            wbfs_pkg::ST_EV_W:     state_next = wbfs_pkg::ST_EV_CHECK;
            wbfs_pkg::ST_RM_WID:   state_next = wbfs_pkg::ST_RM_RD;
            wbfs_pkg::ST_RM_RD:
            begin
                state_next = (r_reg < count_reg) ? wbfs_pkg::ST_RM_DATA : wbfs_pkg::ST_IDLE;
            end
            wbfs_pkg::ST_RM_DATA:  state_next = wbfs_pkg::ST_RM_RD;
            wbfs_pkg::ST_DUMP_RD:  state_next = wbfs_pkg::ST_DUMP_OUT;
            wbfs_pkg::ST_DUMP_OUT:
            begin
                if (out_free)
                begin
                    state_next = dump_last ? wbfs_pkg::ST_IDLE : wbfs_pkg::ST_DUMP_RD;
                end
            end
            default:               state_next = wbfs_pkg::ST_IDLE;
        endcase
    end

    // datapath and ram controls
    always_comb
    begin
        cap_next       = cfg_we ? cfg_wdata : cap_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        ovf_next       = ovf_reg;
        prob_next      = prob_reg;
        r_next         = r_reg;
        k_next         = k_reg;
        id_next        = id_reg;
        wadd_next      = wadd_reg;
        wsub_next      = wsub_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_id_next    = out_id_reg;
        out_prob_next  = out_prob_reg;
        out_empty_next = out_empty_reg;
        out_ovf_next   = out_ovf_reg;
        out_last_next  = out_last_reg;
        o_we           = 1'b0;
        o_waddr        = phys;
        o_wdata        = o_rdata;
        o_re           = 1'b0;
        o_raddr        = phys;
        w_we           = 1'b0;
        w_waddr        = wt_addr(id_reg);
        w_wdata        = wadd_reg;
        w_re           = 1'b0;
        w_raddr        = wt_addr(o_rdata);

        case (state_reg)
            wbfs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    id_next   = req.item_id;
                    wadd_next = req.item_width;
                    r_next    = '0;
                    k_next    = '0;
                    case (req.cmd)
                        wbfs_pkg::CMD_ADD:
                        begin
                            if (id_ok && (count_reg >= CW'(SLOTS)))
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        wbfs_pkg::CMD_REMOVE:
                        begin
                            w_re    = 1'b1;
                            w_raddr = wt_addr(req.item_id);
                        end
                        wbfs_pkg::CMD_END:
                        begin
                            prob_next = (prob_reg == wbfs_pkg::PROB_MAX) ? PROB_W'(1)
                                                                         : prob_reg + 1'b1;
                        end
                        default:
                        begin
                            id_next = req.item_id;
                        end
                    endcase
                end
            end
            wbfs_pkg::ST_ADD:
            begin
                head_next  = head_dec;
                o_we       = 1'b1;
                o_waddr    = head_dec;
                o_wdata    = id_reg;
                w_we       = 1'b1;
                count_next = count_reg + 1'b1;
                sum_next   = sum_reg + SUM_W'(wadd_reg);
            end
            wbfs_pkg::ST_EV_CHECK:
            begin
                if (evict)
                begin
                    o_re       = 1'b1;
                    count_next = count_reg - 1'b1;
                end
                else if (count_reg == '0)
                begin
                    sum_next = '0;
                end
            end
            wbfs_pkg::ST_EV_ID:
            begin
                w_re = 1'b1;
            end
            wbfs_pkg::ST_EV_W:
            begin
                sum_next = sat_sub(sum_reg, w_rdata);
            end
            wbfs_pkg::ST_RM_WID:
            begin
                wsub_next = w_rdata;
            end
            wbfs_pkg::ST_RM_RD:
            begin
                if (r_reg < count_reg)
                begin
                    o_re = 1'b1;
                end
                else
                begin
                    count_next = k_reg;
                    if (k_reg == '0)
                    begin
                        sum_next = '0;
                    end
                end
            end
            wbfs_pkg::ST_RM_DATA:
            begin
                if (o_rdata == id_reg)
                begin
                    sum_next = sat_sub(sum_reg, wsub_reg);
                end
                else
                begin
                    o_we   = 1'b1;
                    k_next = k_reg + 1'b1;
                end
                r_next = r_inc;
            end
            wbfs_pkg::ST_DUMP_RD:
            begin
                o_re = 1'b1;
            end
            wbfs_pkg::ST_DUMP_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_id_next    = (count_reg == '0) ? '0 : o_rdata;
                    out_prob_next  = prob_reg;
                    out_empty_next = (count_reg == '0);
                    out_ovf_next   = ovf_reg;
                    out_last_next  = dump_last;
                    r_next         = r_inc;
                    if (dump_last)
                    begin
                        count_next = '0;
                        sum_next   = '0;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                r_next = r_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wbfs_pkg::ST_IDLE;
            cap_reg       <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            ovf_reg       <= 1'b0;
            prob_reg      <= '0;
            r_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            ovf_reg       <= ovf_next;
            prob_reg      <= prob_next;
            r_reg         <= r_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg        <= id_next;
        wadd_reg      <= wadd_next;
        wsub_reg      <= wsub_next;
        out_id_reg    <= out_id_next;
        out_prob_reg  <= out_prob_next;
        out_empty_reg <= out_empty_next;
        out_ovf_reg   <= out_ovf_next;
        out_last_reg  <= out_last_next;
    end

    assign req.ready          = (state_reg == wbfs_pkg::ST_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.out_id         = out_id_reg;
    assign rsp.problem_number = out_prob_reg;
    assign rsp.list_empty     = out_empty_reg;
    assign rsp.overflow       = out_ovf_reg;
    assign rsp.last           = out_last_reg;

endmodule
